### src/srp_pkg.sv
// serpent cipher package: types, s-box tables and round functions
`timescale 1ns / 1ps

package srp_pkg;

    localparam int ROUNDS_DEF = 32;
    localparam int TDATA_IN_W = 168;
    localparam int TDATA_OUT_W = 128;

    typedef logic [31:0] word_t;
    typedef word_t [3:0] block_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ENC   = 2'd1,
        OP_DEC   = 2'd2
    } op_t;

    typedef struct packed {
        op_t    op;
        block_t data;
    } item_t;

    localparam logic [3:0] SBOX_TAB [0:7][0:15] = '{
        '{4'h3, 4'h8, 4'hf, 4'h1, 4'ha, 4'h6, 4'h5, 4'hb,
          4'he, 4'hd, 4'h4, 4'h2, 4'h7, 4'h0, 4'h9, 4'hc},
        '{4'hf, 4'hc, 4'h2, 4'h7, 4'h9, 4'h0, 4'h5, 4'ha,
          4'h1, 4'hb, 4'he, 4'h8, 4'h6, 4'hd, 4'h3, 4'h4},
        '{4'h8, 4'h6, 4'h7, 4'h9, 4'h3, 4'hc, 4'ha, 4'hf,
          4'hd, 4'h1, 4'he, 4'h4, 4'h0, 4'hb, 4'h5, 4'h2},
        '{4'h0, 4'hf, 4'hb, 4'h8, 4'hc, 4'h9, 4'h6, 4'h3,
          4'hd, 4'h1, 4'h2, 4'h4, 4'ha, 4'h7, 4'h5, 4'he},
        '{4'h1, 4'hf, 4'h8, 4'h3, 4'hc, 4'h0, 4'hb, 4'h6,
          4'h2, 4'h5, 4'h4, 4'ha, 4'h9, 4'he, 4'h7, 4'hd},
        '{4'hf, 4'h5, 4'h2, 4'hb, 4'h4, 4'ha, 4'h9, 4'hc,
          4'h0, 4'h3, 4'he, 4'h8, 4'hd, 4'h6, 4'h7, 4'h1},
        '{4'h7, 4'h2, 4'hc, 4'h5, 4'h8, 4'h4, 4'h6, 4'hb,
          4'he, 4'h9, 4'h1, 4'hf, 4'hd, 4'h3, 4'ha, 4'h0},
        '{4'h1, 4'hd, 4'hf, 4'h0, 4'he, 4'h8, 4'h2, 4'hb,
          4'h7, 4'h4, 4'hc, 4'ha, 4'h9, 4'h3, 4'h5, 4'h6}
    };

    function automatic word_t rol32(word_t x, int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic word_t ror32(word_t x, int unsigned n);
        return rol32(x, 32 - n);
    endfunction

    function automatic logic [3:0] sbox_inv(int box, logic [3:0] v);
        logic [3:0] res;
        res = 4'h0;
        for (int i = 0; i < 16; i++) begin
            if (SBOX_TAB[box][i] == v) begin
                res = 4'(i);
            end
        end
        return res;
    endfunction

    function automatic block_t sbox_layer(block_t w, int box, logic inverse);
        block_t     r;
        logic [3:0] nib;
        logic [3:0] o;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            nib = {w[3][i], w[2][i], w[1][i], w[0][i]};
            o = inverse ? sbox_inv(box, nib) : SBOX_TAB[box][nib];
            r[0][i] = o[0];
            r[1][i] = o[1];
            r[2][i] = o[2];
            r[3][i] = o[3];
        end
        return r;
    endfunction

    function automatic block_t lin_fwd(block_t x);
        block_t w;
        w = x;
        w[0] = rol32(w[0], 13);
        w[2] = rol32(w[2], 3);
        w[1] = w[1] ^ w[0] ^ w[2];
        w[3] = w[3] ^ w[2] ^ (w[0] << 3);
        w[1] = rol32(w[1], 1);
        w[3] = rol32(w[3], 7);
        w[0] = w[0] ^ w[1] ^ w[3];
        w[2] = w[2] ^ w[3] ^ (w[1] << 7);
        w[0] = rol32(w[0], 5);
        w[2] = rol32(w[2], 22);
        return w;
    endfunction

    function automatic block_t lin_inv(block_t x);
        block_t w;
        w = x;
        w[2] = ror32(w[2], 22);
        w[0] = ror32(w[0], 5);
        w[2] = w[2] ^ w[3] ^ (w[1] << 7);
        w[0] = w[0] ^ w[1] ^ w[3];
        w[3] = ror32(w[3], 7);
        w[1] = ror32(w[1], 1);
        w[3] = w[3] ^ w[2] ^ (w[0] << 3);
        w[1] = w[1] ^ w[0] ^ w[2];
        w[2] = ror32(w[2], 3);
        w[0] = ror32(w[0], 13);
        return w;
    endfunction

endpackage

### src/srp_round.sv
// one serpent round pipeline stage with its own round key registers
`timescale 1ns / 1ps

module srp_round #(
    parameter int ROUNDS = srp_pkg::ROUNDS_DEF,
    parameter int STAGE  = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  srp_pkg::item_t  in_item,
    output logic            in_ready,
    output logic            out_valid,
    output srp_pkg::item_t  out_item,
    input  logic            out_ready
);
    import srp_pkg::*;

    localparam int ENC_BOX = STAGE % 8;
    localparam int DEC_BOX = (ROUNDS - 1 - STAGE) % 8;
    localparam bit IS_FIRST = (STAGE == 0);
    localparam bit IS_LAST = (STAGE == ROUNDS - 1);
    localparam logic [5:0] ENC_ROW = 6'(STAGE);
    localparam logic [5:0] DEC_ROW = 6'(ROUNDS - 1 - STAGE);
    localparam logic [5:0] FIN_ROW = 6'(ROUNDS);

    logic   valid_reg;
    item_t  item_reg;
    item_t  item_next;
    block_t enc_key_reg;
    block_t dec_key_reg;
    block_t fin_key;
    block_t t;
    logic   key_wr;
    logic [5:0] row;
    logic [1:0] slot;
    word_t  word;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    assign key_wr = in_valid && in_ready && (in_item.op == OP_WRITE);
    assign row    = in_item.data[0][7:2];
    assign slot   = in_item.data[0][1:0];
    assign word   = {in_item.data[1][7:0], in_item.data[0][31:8]};

    always_ff @(posedge aclk) begin
        if (key_wr && row == ENC_ROW) begin
            enc_key_reg[slot] <= word;
        end
        if (key_wr && row == DEC_ROW) begin
            dec_key_reg[slot] <= word;
        end
    end

    // final key words are needed only at the two ends of the pipeline
    if (IS_FIRST || IS_LAST) begin : g_fin
        block_t fin_key_reg;
        always_ff @(posedge aclk) begin
            if (key_wr && row == FIN_ROW) begin
                fin_key_reg[slot] <= word;
            end
        end
        assign fin_key = fin_key_reg;
    end else begin : g_no_fin
        assign fin_key = '0;
    end

    always_comb begin
        item_next = in_item;
        t = in_item.data;
        unique case (in_item.op)
            OP_ENC: begin
                t = sbox_layer(t ^ enc_key_reg, ENC_BOX, 1'b0);
                t = IS_LAST ? (t ^ fin_key) : lin_fwd(t);
                item_next.data = t;
            end
            OP_DEC: begin
                if (IS_FIRST) begin
                    t = t ^ fin_key;
                end
                t = sbox_layer(t, DEC_BOX, 1'b1) ^ dec_key_reg;
                item_next.data = IS_LAST ? t : lin_inv(t);
            end
            default: begin
                item_next = in_item;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

### src/serpent_block_cipher.sv
// serpent block cipher top level: stream ports and the unrolled round pipeline
// Serpent-128 encrypt/decrypt with one round per pipeline stage: a block beat passes
// through the chain of round stages from acceptance to its result, and one block can
// enter every cycle while m_tready does not stall the output. Round key words are
// loaded with beats of kind 0 that travel down the same pipeline and update each
// stage's own key registers as they pass, so every block sees exactly the keys
// written before it and no block already in flight is disturbed. Key beats,
// out-of-range key indexes and kind 3 give no result. Key registers are not
// cleared by reset and must be loaded before use.
`timescale 1ns / 1ps

module serpent_block_cipher #(
    parameter int ROUNDS = srp_pkg::ROUNDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key_index[7:0], key_word[39:8], block_lo[103:40], block_hi[167:104]
    input  logic [srp_pkg::TDATA_IN_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_lo[63:0], result_hi[127:64]
    output logic [srp_pkg::TDATA_OUT_W-1:0] m_tdata
);
    import srp_pkg::*;

    logic  stage_valid [0:ROUNDS];
    item_t stage_item  [0:ROUNDS];
    logic  stage_ready [0:ROUNDS];
    op_t   kind;
    logic  last_is_write;

    assign kind = op_t'(s_tuser);

    // kind 3 beats are taken and dropped
    assign stage_valid[0] = s_tvalid &&
        (kind == OP_WRITE || kind == OP_ENC || kind == OP_DEC);
    assign s_tready = stage_ready[0];

    always_comb begin
        stage_item[0].op = kind;
        if (kind == OP_WRITE) begin
            stage_item[0].data = {88'b0, s_tdata[39:0]};
        end else begin
            stage_item[0].data = s_tdata[167:40];
        end
    end

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        srp_round #(
            .ROUNDS (ROUNDS),
            .STAGE  (g)
        ) u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[g]),
            .in_item   (stage_item[g]),
            .in_ready  (stage_ready[g]),
            .out_valid (stage_valid[g+1]),
            .out_item  (stage_item[g+1]),
            .out_ready (stage_ready[g+1])
        );
    end

    // key beats leave the last stage without showing on the output
    assign last_is_write = stage_item[ROUNDS].op == OP_WRITE;
    assign stage_ready[ROUNDS] = m_tready || last_is_write;
    assign m_tvalid = stage_valid[ROUNDS] && !last_is_write;
    assign m_tdata  = stage_item[ROUNDS].data;

    a_full_means_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    a_ready_propagates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("output ready did not reach the input");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
